/* design/tppb_pkg.sv */
// ---------------------------------------------------------------------------
// tppb_pkg
// Shared types and constants for the tiled page pixel box plotter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tppb_pkg;

    localparam int COORD_W     = 8;   // on-screen coordinate width
    localparam int TILE_W      = 16;  // byte offset within one page
    localparam int BAND_SIZE   = 16384;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_POINT = 2'd0,
        OP_BOX   = 2'd1,
        OP_FILL  = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_DRAW_PAGE     = 2'd0,
        REG_XOR_MODE      = 2'd1,
        REG_DEFAULT_COLOR = 2'd2
    } t_reg;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    // Classified command: op flags, clipped walk range, outline edge flags and colour.
    typedef struct packed {
        logic               read;
        logic               outline;
        logic               empty;
        logic [COORD_W-1:0] lx;
        logic [COORD_W-1:0] hx;
        logic [COORD_W-1:0] ly;
        logic [COORD_W-1:0] hy;
        logic               left_on;
        logic               right_on;
        logic               top_on;
        logic               bot_on;
        logic [7:0]         color;
    } t_cmd;

    // 8x8 tiled byte order inside one page
    function automatic logic [TILE_W-1:0] tile_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y);
        tile_addr = {y[7:6], x[7:6], y[5:3], x[5:3], y[2:0], x[2:0]};
    endfunction

endpackage

`default_nettype wire

/* design/tppb_front.sv */
// ---------------------------------------------------------------------------
// tppb_front
// Command classifier: orders corners, clips to the screen, picks the colour.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tppb_front
    import tppb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 192
) (
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [15:0] i_x_first,
    input  wire logic signed [15:0] i_y_first,
    input  wire logic signed [15:0] i_x_second,
    input  wire logic signed [15:0] i_y_second,
    input  wire logic               i_color_given,
    input  wire logic [7:0]         i_color,
    input  wire logic [7:0]         i_default_color,
    output t_cmd                    o_cmd
);

    localparam logic signed [16:0] XMAX = 17'(SCREEN_WIDTH - 1);
    localparam logic signed [16:0] YMAX = 17'(SCREEN_HEIGHT - 1);

    logic              is_box;
    logic signed [15:0] bx, ex, by, ey;

    always_comb begin
        is_box = (i_operation == OP_BOX) || (i_operation == OP_FILL);
        if (is_box) begin
            bx = (i_x_first < i_x_second) ? i_x_first : i_x_second;
            ex = (i_x_first < i_x_second) ? i_x_second : i_x_first;
            by = (i_y_first < i_y_second) ? i_y_first : i_y_second;
            ey = (i_y_first < i_y_second) ? i_y_second : i_y_first;
        end else begin
            bx = i_x_first;
            ex = i_x_first;
            by = i_y_first;
            ey = i_y_first;
        end

        o_cmd.read    = (i_operation == OP_READ);
        o_cmd.outline = (i_operation == OP_BOX);
        o_cmd.empty   = ex[15] || (17'(bx) > XMAX) || ey[15] || (17'(by) > YMAX);
        o_cmd.lx      = bx[15] ? '0 : bx[COORD_W-1:0];
        o_cmd.hx      = (17'(ex) > XMAX) ? XMAX[COORD_W-1:0] : ex[COORD_W-1:0];
        o_cmd.ly      = by[15] ? '0 : by[COORD_W-1:0];
        o_cmd.hy      = (17'(ey) > YMAX) ? YMAX[COORD_W-1:0] : ey[COORD_W-1:0];
        // an outline edge is drawn only if the unclipped edge is on screen
        o_cmd.left_on  = !bx[15];
        o_cmd.right_on = (17'(ex) <= XMAX);
        o_cmd.top_on   = !by[15];
        o_cmd.bot_on   = (17'(ey) <= YMAX);
        o_cmd.color    = i_color_given ? i_color : i_default_color;
    end

endmodule

`default_nettype wire

/* design/tppb_queue.sv */
// ---------------------------------------------------------------------------
// tppb_queue
// Short command FIFO between classifier and pixel engine.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tppb_queue
    import tppb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic [QPTR_W-1:0] n_wr, n_rd;
    logic [QPTR_W:0]   n_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? QPTR_W'(r_wr + 1'b1) : r_wr;
        n_rd  = i_pop  ? QPTR_W'(r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/tppb_back.sv */
// ---------------------------------------------------------------------------
// tppb_back
// Pixel engine: clearing pass, rectangle walk, read-modify-write on the page
// store and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tppb_back
    import tppb_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 192,
    parameter int PAGE_COUNT    = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_draw_page,
    input  wire logic       i_xor_mode,
    input  wire logic       i_q_empty,
    input  wire t_cmd       i_q_cmd,
    output logic            o_q_pop,
    output logic            o_clearing,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_read_value,
    output logic            o_read_in_range
);

    localparam int BAND_ROWS   = (SCREEN_HEIGHT + 63) / 64;
    localparam int PAGE_STRIDE = BAND_SIZE * BAND_ROWS;
    localparam int DEPTH       = PAGE_COUNT * PAGE_STRIDE;
    localparam int ADDR_W      = $clog2(DEPTH);

    logic [7:0]        r_mem [DEPTH];
    logic [7:0]        r_rd_data;

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [COORD_W-1:0] r_x, r_y, n_x, n_y;
    logic [ADDR_W-1:0] r_clr_addr;

    // stage 1: memory data returns
    logic              r_s1_valid, r_s1_we, r_s1_last, r_s1_read, r_s1_in_range;
    logic              r_s1_page_ok, r_s1_xor;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [7:0]        r_s1_color;

    // last completed write, for a read issued in the same cycle
    logic              r_fw_valid;
    logic [ADDR_W-1:0] r_fw_addr;
    logic [7:0]        r_fw_data;

    logic              r_out_valid;
    logic [7:0]        r_out_value;
    logic              r_out_in_range;

    logic              page_ok, edge_hit, issue, issue_we, issue_last;
    logic [ADDR_W-1:0] issue_addr;
    logic [7:0]        s1_data, s1_wdata;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;

    assign page_ok = (int'(i_draw_page) < PAGE_COUNT);

    always_comb begin
        edge_hit   = (r_cmd.left_on  && (r_x == r_cmd.lx)) ||
                     (r_cmd.right_on && (r_x == r_cmd.hx)) ||
                     (r_cmd.top_on   && (r_y == r_cmd.ly)) ||
                     (r_cmd.bot_on   && (r_y == r_cmd.hy));
        issue_addr = ADDR_W'(ADDR_W'(i_draw_page) * ADDR_W'(PAGE_STRIDE))
                   + ADDR_W'(tile_addr(r_x, r_y));
        issue_we   = !r_cmd.empty && page_ok && !r_cmd.read
                   && (!r_cmd.outline || edge_hit);
        issue_last = r_cmd.empty || ((r_x == r_cmd.hx) && (r_y == r_cmd.hy));
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        o_q_pop = 1'b0;
        issue   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_q_empty && !r_s1_valid && !r_out_valid) begin
                    o_q_pop = 1'b1;
                    n_x     = i_q_cmd.lx;
                    n_y     = i_q_cmd.ly;
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                issue = 1'b1;
                if (r_y == r_cmd.hy) begin
                    n_y = r_cmd.ly;
                    n_x = r_x + 1'b1;
                end else begin
                    n_y = r_y + 1'b1;
                end
                if (issue_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

    // stage 1 data and write-back
    always_comb begin
        s1_data  = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : r_rd_data;
        s1_wdata = r_s1_xor ? (s1_data ^ r_s1_color) : r_s1_color;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = r_s1_valid && r_s1_we;
            mem_waddr = r_s1_addr;
            mem_wdata = s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[issue_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            r_fw_valid <= r_s1_valid && r_s1_we;
            if (r_s1_valid && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_we       <= issue_we;
        r_s1_last     <= issue_last;
        r_s1_read     <= r_cmd.read;
        r_s1_in_range <= r_cmd.read && !r_cmd.empty;
        r_s1_page_ok  <= page_ok;
        r_s1_xor      <= i_xor_mode;
        r_s1_addr     <= issue_addr;
        r_s1_color    <= r_cmd.color;
        r_fw_addr     <= r_s1_addr;
        r_fw_data     <= s1_wdata;
        if (r_s1_valid && r_s1_last) begin
            r_out_value    <= (r_s1_in_range && r_s1_page_ok) ? s1_data : '0;
            r_out_in_range <= r_s1_in_range;
        end
    end

    assign o_clearing      = (r_state == ST_CLEAR);
    assign o_valid         = r_out_valid;
    assign o_read_value    = r_out_value;
    assign o_read_in_range = r_out_in_range;

`ifndef ASSERT_OFF
    a_no_pixel_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_s1_valid)
        else $error("pixel in flight during clearing pass");

    a_pop_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (!r_s1_valid && !r_out_valid))
        else $error("command popped while previous one in flight");

    a_walk_in_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && !r_cmd.empty) |->
        (r_x >= r_cmd.lx && r_x <= r_cmd.hx && r_y >= r_cmd.ly && r_y <= r_cmd.hy))
        else $error("walk left clipped rectangle");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |=> r_out_valid)
        else $error("finished command produced no result");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_read) |-> !r_s1_we)
        else $error("read command wrote the store");
`endif

endmodule

`default_nettype wire

/* design/tiled_page_pixel_box_plotter_unit.sv */
// Walk: a box steps through each pixel of its clipped rectangle (outline boxes walk it
//   all); a point or a read walks a single pixel before its result is given.
// Throughput: one command at a time, set by the pixel walk over the single store
//   write port; up to QUEUE_DEPTH commands are taken in ahead into the queue.
// Reset: control registers reset; a clearing pass zeroes the page store, one byte a cycle,
//   all PAGE_COUNT*16384*ceil(SCREEN_HEIGHT/64) bytes of it, with input stalled meanwhile.
// ---------------------------------------------------------------------------
// tiled_page_pixel_box_plotter_unit
// Drawing engine over tiled byte pages: point, box outline, fill and read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tiled_page_pixel_box_plotter_unit
    import tppb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 192,
    parameter int PAGE_COUNT    = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // command channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [15:0] i_x_first,
    input  wire logic signed [15:0] i_y_first,
    input  wire logic signed [15:0] i_x_second,
    input  wire logic signed [15:0] i_y_second,
    input  wire logic               i_color_given,
    input  wire logic [7:0]         i_color,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [7:0]              o_read_value,
    output logic                    o_read_in_range,
    // configuration write
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);

    logic [1:0] r_draw_page;
    logic       r_xor_mode;
    logic [7:0] r_default_color;

    t_cmd front_cmd, q_cmd;
    logic q_full, q_empty, q_pop, clearing, push;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_page     <= '0;
            r_xor_mode      <= 1'b0;
            r_default_color <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DRAW_PAGE:     r_draw_page     <= i_cfg_data[1:0];
                REG_XOR_MODE:      r_xor_mode      <= i_cfg_data[0];
                REG_DEFAULT_COLOR: r_default_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall = clearing || q_full;
    assign push    = i_valid && !o_stall;

    tppb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_operation     (i_operation),
        .i_x_first       (i_x_first),
        .i_y_first       (i_y_first),
        .i_x_second      (i_x_second),
        .i_y_second      (i_y_second),
        .i_color_given   (i_color_given),
        .i_color         (i_color),
        .i_default_color (r_default_color),
        .o_cmd           (front_cmd)
    );

    tppb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    tppb_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .PAGE_COUNT    (PAGE_COUNT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_draw_page     (r_draw_page),
        .i_xor_mode      (r_xor_mode),
        .i_q_empty       (q_empty),
        .i_q_cmd         (q_cmd),
        .o_q_pop         (q_pop),
        .o_clearing      (clearing),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_read_value    (o_read_value),
        .o_read_in_range (o_read_in_range)
    );

endmodule

`default_nettype wire
